>>> design/mp3_vbr_header_scanner_assert.svh
// assertion macros shared by the checker of the vbr header scanner
`ifndef MP3_VBR_HEADER_SCANNER_ASSERT_SVH
`define MP3_VBR_HEADER_SCANNER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MP3VBR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MP3VBR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/mp3vbr_pkg.sv
// types and constants of the mp3 vbr header scanner
`timescale 1ns / 1ps

package mp3vbr_pkg;

   // sliding byte window
   localparam int WINDOW_BYTES = 19;
   localparam int NEWEST       = WINDOW_BYTES - 1;

   // scan window register reset
   localparam logic [15:0] SCAN_WINDOW_RESET = 16'd1900;

   // offsets and limits
   localparam logic [28:0] OFFSET_MAX       = '1;
   localparam logic [28:0] ID3_LAST_OFFSET  = 29'd9;
   localparam logic [28:0] ID3_HEADER_BYTES = 29'd10;
   localparam logic [28:0] AUDIO_START_MAX  = 29'd268435465;
   localparam logic [29:0] SIG_SPAN         = 30'd12;
   localparam logic [2:0]  VBRI_COUNT_WAIT  = 3'd6;

   // signature byte strings
   localparam logic [23:0] SIG_ID3  = 24'h494433;
   localparam logic [31:0] SIG_XING = 32'h58696E67;
   localparam logic [31:0] SIG_INFO = 32'h496E666F;
   localparam logic [31:0] SIG_VBRI = 32'h56425249;

   // header kinds as reported on the result word
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_XING = 2'd1,
      KIND_INFO = 2'd2,
      KIND_VBRI = 2'd3
   } kind_type;

   // one result word
   typedef struct packed {
      logic [28:0] audio_start;
      logic [31:0] frame_count;
      logic        is_vbr;
      kind_type    header_kind;
   } result_type;

endpackage

>>> design/mp3vbr_scan_core.sv
// byte window, id3 skip and signature search of the vbr header scanner
`timescale 1ns / 1ps

module mp3vbr_scan_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   input  logic [15:0]            scan_window,
   output logic                   res_valid,
   output mp3vbr_pkg::result_type res
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SCAN,
      PH_VBRI,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [28:0] offset_ff, offset_in;
   logic [28:0] start_ff, start_in, start_upd;
   logic [2:0]  wait_ff, wait_in, wait_dec;
   logic [7:0]  win_ff [mp3vbr_pkg::WINDOW_BYTES];
   logic [7:0]  win_in [mp3vbr_pkg::WINDOW_BYTES];

   logic [29:0] offset_w, limit, cand_lo;
   logic        in_range, below_limit, is_id3, is_xing, is_info, is_vbri, emit;
   logic [27:0] tag_size;
   logic [31:0] count_word;

   // shift the new byte into the newest place of the window
   always_comb begin
      for (int k = 0; k < mp3vbr_pkg::NEWEST; k++) begin
         win_in[k] = win_ff[k + 1];
      end
      win_in[mp3vbr_pkg::NEWEST] = data_byte;
   end

   // window compares and offset bounds
   always_comb begin
      offset_w    = {1'b0, offset_ff};
      limit       = {1'b0, start_ff} + {14'd0, scan_window};
      cand_lo     = {1'b0, start_ff} + mp3vbr_pkg::SIG_SPAN;
      in_range    = (offset_w >= cand_lo) && (offset_w < limit);
      below_limit = offset_w < limit;
      is_id3      = {win_in[9], win_in[10], win_in[11]} == mp3vbr_pkg::SIG_ID3;
      tag_size    = {win_in[15][6:0], win_in[16][6:0], win_in[17][6:0], win_in[18][6:0]};
      is_xing     = {win_in[6], win_in[7], win_in[8], win_in[9]} == mp3vbr_pkg::SIG_XING;
      is_info     = {win_in[6], win_in[7], win_in[8], win_in[9]} == mp3vbr_pkg::SIG_INFO;
      is_vbri     = {win_in[6], win_in[7], win_in[8], win_in[9]} == mp3vbr_pkg::SIG_VBRI;
      count_word  = {win_in[14], win_in[15], win_in[16], win_in[17]};
   end

   // next state and result for the accepted byte
   always_comb begin
      offset_in = (offset_ff == mp3vbr_pkg::OFFSET_MAX) ? offset_ff : offset_ff + 29'd1;
      start_upd = start_ff;
      phase_in  = phase_ff;
      wait_in   = wait_ff;
      wait_dec  = (wait_ff != 3'd0) ? wait_ff - 3'd1 : wait_ff;
      emit      = 1'b0;
      res.header_kind = mp3vbr_pkg::KIND_NONE;
      res.frame_count = '0;

      case (phase_ff)
         PH_HEADER: begin
            // bytes 0 to 9 are in place: work out where the audio starts
            if (offset_ff == mp3vbr_pkg::ID3_LAST_OFFSET) begin
               start_upd = is_id3 ? ({1'b0, tag_size} + mp3vbr_pkg::ID3_HEADER_BYTES) : '0;
               phase_in  = PH_SCAN;
            end
         end
         PH_SCAN: begin
            if (in_range) begin
               if (is_xing || is_info) begin
                  emit            = 1'b1;
                  res.header_kind = is_xing ? mp3vbr_pkg::KIND_XING : mp3vbr_pkg::KIND_INFO;
                  res.frame_count = win_in[13][0] ? count_word : '0;
                  phase_in        = PH_DONE;
               end else if (is_vbri) begin
                  phase_in = PH_VBRI;
                  wait_in  = mp3vbr_pkg::VBRI_COUNT_WAIT;
               end
            end
         end
         PH_VBRI: begin
            // vbri count bytes arrive six bytes after the signature test
            wait_in = wait_dec;
            if (wait_dec == 3'd0) begin
               emit            = 1'b1;
               res.header_kind = mp3vbr_pkg::KIND_VBRI;
               res.frame_count = below_limit ? count_word : '0;
               phase_in        = PH_DONE;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      // end of file flushes any pending result
      if (last_byte && !emit && (phase_in != PH_DONE)) begin
         emit            = 1'b1;
         res.header_kind = (phase_in == PH_VBRI) ? mp3vbr_pkg::KIND_VBRI
                                                 : mp3vbr_pkg::KIND_NONE;
         res.frame_count = '0;
      end

      res.is_vbr      = (res.header_kind == mp3vbr_pkg::KIND_XING) ||
                        (res.header_kind == mp3vbr_pkg::KIND_VBRI);
      res.audio_start = start_upd;
      start_in        = start_upd;

      // the final byte returns the scanner to the start of a file
      if (last_byte) begin
         offset_in = '0;
         start_in  = '0;
         phase_in  = PH_HEADER;
         wait_in   = '0;
      end
   end

   assign res_valid = in_valid && emit;

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         offset_ff <= '0;
         start_ff  <= '0;
         wait_ff   <= '0;
      end else if (in_valid) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         start_ff  <= start_in;
         wait_ff   <= wait_in;
      end
   end

   // byte window, only read at places already filled by the current file
   always_ff @(posedge clock) begin
      if (in_valid) begin
         win_ff <= win_in;
      end
   end

endmodule

>>> design/mp3_vbr_header_scanner.sv
// top level of the mp3 vbr header scanner
`timescale 1ns / 1ps

// Takes one file byte per cycle on req_ and returns one result word per file on rsp_.
// Each accepted byte is handled in the same cycle by the window compare and offset
// logic, so a file streams at one byte a cycle unless stalled; a result is registered
// into the output buffer on the byte that completes it (the Xing/Info signature test,
// the sixth byte after the VBRI signature test, or the byte flagged with req_tlast).
// Results sit in a two-word output buffer, and req_tready drops only while both words
// wait to be taken. csr_wdata sets the scan window in bytes after the audio start
// (reset 1900); write it only between files.

module mp3_vbr_header_scanner (
   input  logic        clock,
   input  logic        reset,
   // scan window register
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata,
   // file bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [1:0] header_kind, [2] is_vbr, [34:3] frame_count,
                                    // [63:35] audio_start
);

   logic [15:0]            scan_window_ff;
   logic [1:0]             count_ff, count_in;
   mp3vbr_pkg::result_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   mp3vbr_pkg::result_type core_res;
   logic                   core_valid, accept, push, pop;

   // scan window register
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_window_ff <= mp3vbr_pkg::SCAN_WINDOW_RESET;
      end else if (csr_wen) begin
         scan_window_ff <= csr_wdata;
      end
   end

   assign req_tready = (count_ff != 2'd2);
   assign accept     = req_tvalid && req_tready;

   mp3vbr_scan_core u_core (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .data_byte   (req_tdata),
      .last_byte   (req_tlast),
      .scan_window (scan_window_ff),
      .res_valid   (core_valid),
      .res         (core_res)
   );

   // two-word output buffer, slot0 is the head
   assign push = core_valid;
   assign pop  = (count_ff != 2'd0) && rsp_tready;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      if (pop) begin
         slot0_in = push ? core_res : slot1_ff;
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_in = core_res;
         end else begin
            slot1_in = core_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = slot0_ff;

endmodule

>>> design/mp3vbr_checker.sv
// port checker of the mp3 vbr header scanner and its bind
`timescale 1ns / 1ps
`include "mp3_vbr_header_scanner_assert.svh"

module mp3vbr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   logic [1:0]  kind;
   logic        vbr_flag;
   logic [31:0] frames;
   logic [28:0] start;

   assign kind     = rsp_tdata[1:0];
   assign vbr_flag = rsp_tdata[2];
   assign frames   = rsp_tdata[34:3];
   assign start    = rsp_tdata[63:35];

   // a stalled result word holds
   `MP3VBR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")

   // vbr flag follows the header kind
   `MP3VBR_ASSERT_SAME(a_vbr_flag, clock, reset, rsp_tvalid,
      vbr_flag == ((kind == mp3vbr_pkg::KIND_XING) || (kind == mp3vbr_pkg::KIND_VBRI)),
      "vbr flag disagrees with header kind")

   // no header means no frame count
   `MP3VBR_ASSERT_SAME(a_none_frames, clock, reset, rsp_tvalid && (kind == mp3vbr_pkg::KIND_NONE),
      frames == 32'd0, "frame count without a header")

   // audio start never beyond the largest id3 tag
   `MP3VBR_ASSERT_SAME(a_start_max, clock, reset, rsp_tvalid,
      start <= mp3vbr_pkg::AUDIO_START_MAX, "audio start out of range")

endmodule

bind mp3_vbr_header_scanner mp3vbr_checker u_checker (.*);
